// ----- rtl/fticu_pkg.sv -----
package fticu_pkg;

  localparam int AXES        = 6;
  localparam int AXIS_W      = $clog2(AXES);
  localparam int SAMPLE_W    = 24;
  localparam int WIN_DEPTH   = 64;
  localparam int SLOT_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int WSUM_W      = SAMPLE_W + FILL_W;
  localparam int CNT_W       = 16;
  localparam int CSUM_W      = SAMPLE_W + CNT_W;
  localparam int RAM_DEPTH   = WIN_DEPTH * AXES;

  localparam int CFG_W       = 23;
  localparam int CFG_IDX_W   = 3;
  localparam int RANGE_W     = 23;
  localparam int MILLI_W     = 10;
  localparam int FREQ_W      = 16;

  // deviation, its square and the root of three summed squares
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int ROOT_W      = DIFF_W;

  // intensities saturate at 30 bits; anything above 1e9 clamps anyway
  localparam int INT_W       = 30;
  localparam int PROD_W      = INT_W + MILLI_W;

  localparam int DIV_NUM_W   = 48;
  localparam int DIV_DEN_W   = 24;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

  // x / 1e6 as ((x >> 6) * ceil(2^38 / 15625)) >> 38, exact for x < 2^30
  localparam int MILLI_PRE   = 6;
  localparam int MILLI_SHIFT = 38;
  localparam int MDIV_W      = INT_W - MILLI_PRE;
  localparam int RECIP_W     = 25;
  localparam int MPROD_W     = MDIV_W + RECIP_W;

  localparam logic [INT_W-1:0] MICRO      = INT_W'(1000000);
  localparam logic [INT_W-1:0] MILLI_HALF = INT_W'(500000);
  localparam logic [INT_W-1:0] COMB_MAX   = INT_W'(1000000000);
  localparam logic [INT_W-1:0] THOUSAND   = INT_W'(1000);
  localparam logic [RECIP_W-1:0] MILLI_RECIP = RECIP_W'(17592187);

  localparam logic [AXIS_W-1:0] FORCE_LAST  = AXIS_W'(2);
  localparam logic [AXIS_W-1:0] TORQUE_LAST = AXIS_W'(AXES - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_SAMPLES = 3'd0,
    CFG_RANGE       = 3'd1,
    CFG_THRESHOLD   = 3'd2,
    CFG_HIGH_FREQ   = 3'd3,
    CFG_LOW_FREQ    = 3'd4,
    CFG_FORCE_GAIN  = 3'd5,
    CFG_TORQUE_GAIN = 3'd6,
    CFG_DEADBAND    = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CAL_ACC,
    ST_REF_START,
    ST_REF_WAIT,
    ST_WIN_RD,
    ST_WIN_WR,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_INT_START,
    ST_INT_WAIT,
    ST_COMB_MUL,
    ST_COMB_ADD,
    ST_MILLI_START,
    ST_MILLI_WAIT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic                 rem_nz;
  } div_rsp_t;

endpackage

// ----- rtl/fticu_if.sv -----
interface fticu_sample_if;
  import fticu_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] force_x;
  logic signed [SAMPLE_W-1:0] force_y;
  logic signed [SAMPLE_W-1:0] force_z;
  logic signed [SAMPLE_W-1:0] torque_x;
  logic signed [SAMPLE_W-1:0] torque_y;
  logic signed [SAMPLE_W-1:0] torque_z;

  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  input ready);
  modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  output ready);
endinterface

interface fticu_result_if;
  import fticu_pkg::*;

  logic               valid;
  logic               ready;
  logic [MILLI_W-1:0] intensity_milli;
  logic [FREQ_W-1:0]  frequency_milli;

  modport source (output valid, intensity_milli, frequency_milli, input ready);
  modport sink   (input valid, intensity_milli, frequency_milli, output ready);
endinterface

// ----- rtl/force_torque_collision_intensity_unit.sv -----
// Force/torque collision intensity unit.
// sample channel: one six-axis force/torque sample per transaction (valid/ready).
// result channel: intensity in thousandths and the chosen frequency per transaction.
// cfg_we/cfg_index/cfg_data write the eight settings; write only while idle.
// The first calibration_samples samples build the reference and give no result;
// afterwards every sample gives exactly one result.
// A calibration sample is only summed; the one that completes calibration also
// runs six reference divisions. A regular sample's time is set by the shared
// bit-serial divider used eight times (six window means, two intensities) plus
// two roots; the rounding to thousandths is a reciprocal multiply.
// One sample is in work at a time; sample.ready is high only when idle.
// The window lives in a 384 x 24 RAM, one read-modify-write per axis.
// Reset: calibration restarts, sums, reference and window fill clear, settings
// return to their defaults. The RAM needs no clearing; the fill count guards it.
// A stalled result stays in the output register; the next sample is still
// accepted and its result waits for the register to free up.
module force_torque_collision_intensity_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fticu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fticu_pkg::CFG_W-1:0]       cfg_data,
  fticu_sample_if.sink                      sample,
  fticu_result_if.source                    result
);
  import fticu_pkg::*;

  localparam int RAM_AW = $clog2(RAM_DEPTH);

  // settings
  logic [CNT_W-1:0]   cal_samples;
  logic [RANGE_W-1:0] fs_range;
  logic [MILLI_W-1:0] det_thr;
  logic [FREQ_W-1:0]  hi_freq;
  logic [FREQ_W-1:0]  lo_freq;
  logic [MILLI_W-1:0] f_gain;
  logic [MILLI_W-1:0] t_gain;
  logic [MILLI_W-1:0] t_db;

  state_t state, state_next;

  logic                       calibrating;
  logic [CNT_W-1:0]           cal_count;
  logic signed [CSUM_W-1:0]   cal_sums [AXES];
  logic signed [SAMPLE_W-1:0] ref_val  [AXES];
  logic signed [WSUM_W-1:0]   win_sums [AXES];
  logic signed [SAMPLE_W-1:0] samp     [AXES];
  logic signed [SAMPLE_W-1:0] avg      [AXES];
  logic [FILL_W-1:0]          win_fill;
  logic [SLOT_W-1:0]          win_slot;
  logic [AXIS_W-1:0]          axis;

  logic [SQ_W-1:0]  sq;
  logic [SQ_W-1:0]  acc;
  logic [SQ_W-1:0]  rt_v;
  logic [SQ_W-1:0]  rt_r;
  logic [SQ_W-1:0]  rt_bit;
  logic [INT_W-1:0] fi;
  logic [INT_W-1:0] ti;
  logic [PROD_W-1:0] p_f;
  logic [PROD_W-1:0] p_t;
  logic [INT_W-1:0] comb;
  logic             div_neg;
  logic [MPROD_W-1:0] milli_prod;

  logic               out_valid;
  logic [MILLI_W-1:0] out_int;
  logic [FREQ_W-1:0]  out_freq;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // combinational helpers
  logic                         accept;
  logic [CNT_W-1:0]             cal_count_next;
  logic [CNT_W-1:0]             cal_need;
  logic                         cal_done;
  logic                         last_axis;
  logic                         grp_end;
  logic                         win_full;
  logic signed [DIV_NUM_W:0]    div_sn;
  logic [DIV_NUM_W-1:0]         div_mag;
  logic [DIV_NUM_W-1:0]         sq_quot;
  logic [RANGE_W-1:0]           range_eff;
  logic signed [DIFF_W-1:0]     diff;
  logic [DIFF_W-1:0]            diff_mag;
  logic [SQ_W-1:0]              rt_trial;
  logic [INT_W-1:0]             int_sat;
  logic [PROD_W:0]              comb_sum;
  logic [INT_W-1:0]             milli_num;
  logic                         out_free;
  logic                         out_load;

  assign accept    = sample.valid && sample.ready;
  assign last_axis = axis == TORQUE_LAST;
  assign grp_end   = (axis == FORCE_LAST) || (axis == TORQUE_LAST);
  assign win_full  = win_fill >= FILL_W'(WIN_DEPTH);
  assign range_eff = (fs_range == '0) ? RANGE_W'(1) : fs_range;
  assign out_free  = !out_valid || result.ready;
  assign out_load  = (state == ST_MILLI_WAIT) && out_free;

  always_comb begin
    cal_count_next = (cal_count == '1) ? cal_count : cal_count + 1'b1;
    cal_need       = (cal_samples == '0) ? CNT_W'(1) : cal_samples;
    cal_done       = cal_count_next >= cal_need;
  end

  // signed numerator 2*sum + n for round-half-up division
  always_comb begin
    if (state == ST_REF_START) begin
      div_sn = ((DIV_NUM_W+1)'(cal_sums[axis]) <<< 1)
             + (DIV_NUM_W+1)'($signed({1'b0, cal_count}));
    end else begin
      div_sn = ((DIV_NUM_W+1)'(win_sums[axis]) <<< 1)
             + (DIV_NUM_W+1)'($signed({1'b0, win_fill}));
    end
    div_mag = div_sn[DIV_NUM_W] ? DIV_NUM_W'(-div_sn) : DIV_NUM_W'(div_sn);
  end

  // floor of the signed quotient from magnitude quotient and remainder
  assign sq_quot = !div_neg ? div_rsp.quot :
                   (div_rsp.rem_nz ? ~div_rsp.quot : -div_rsp.quot);

  always_comb begin
    diff      = DIFF_W'(avg[axis]) - DIFF_W'(ref_val[axis]);
    diff_mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    rt_trial  = rt_r + rt_bit;
    int_sat   = (|div_rsp.quot[DIV_NUM_W-1:INT_W]) ? '1 : div_rsp.quot[INT_W-1:0];
    comb_sum  = (PROD_W+1)'(p_f) + (PROD_W+1)'(p_t);
    milli_num = comb + MILLI_HALF;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:        if (accept) state_next = calibrating ? ST_CAL_ACC : ST_WIN_RD;
      ST_CAL_ACC:     state_next = cal_done ? ST_REF_START : ST_IDLE;
      ST_REF_START:   state_next = ST_REF_WAIT;
      ST_REF_WAIT:    if (div_rsp.done) state_next = last_axis ? ST_IDLE : ST_REF_START;
      ST_WIN_RD:      state_next = ST_WIN_WR;
      ST_WIN_WR:      state_next = last_axis ? ST_AVG_START : ST_WIN_RD;
      ST_AVG_START:   state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:    if (div_rsp.done) state_next = last_axis ? ST_SQ_MUL : ST_AVG_START;
      ST_SQ_MUL:      state_next = ST_SQ_ACC;
      ST_SQ_ACC:      state_next = grp_end ? ST_SQRT_INIT : ST_SQ_MUL;
      ST_SQRT_INIT:   state_next = ST_SQRT;
      ST_SQRT:        if (rt_bit == SQ_W'(1)) state_next = ST_INT_START;
      ST_INT_START:   state_next = ST_INT_WAIT;
      ST_INT_WAIT: begin
        if (div_rsp.done) state_next = (axis == FORCE_LAST) ? ST_SQ_MUL : ST_COMB_MUL;
      end
      ST_COMB_MUL:    state_next = ST_COMB_ADD;
      ST_COMB_ADD:    state_next = ST_MILLI_START;
      ST_MILLI_START: state_next = ST_MILLI_WAIT;
      ST_MILLI_WAIT:  if (out_load) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    div_req = '0;
    ram_we  = 1'b0;
    case (state)
      ST_REF_START: begin
        div_req.start = 1'b1;
        div_req.num   = div_mag;
        div_req.den   = DIV_DEN_W'({cal_count, 1'b0});
      end
      ST_AVG_START: begin
        div_req.start = 1'b1;
        div_req.num   = div_mag;
        div_req.den   = DIV_DEN_W'({win_fill, 1'b0});
      end
      ST_INT_START: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(rt_r[ROOT_W-1:0]) * DIV_NUM_W'(MICRO);
        div_req.den   = DIV_DEN_W'(range_eff);
      end
      ST_WIN_WR:      ram_we = 1'b1;
      default: begin
        div_req = '0;
        ram_we  = 1'b0;
      end
    endcase
  end

  assign ram_addr = RAM_AW'(int'(win_slot) * AXES + int'(axis));

  fticu_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RAM_DEPTH)
  ) u_win_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(samp[axis]),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  fticu_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // settings
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CNT_W'(500);
      fs_range    <= RANGE_W'(6144);
      det_thr     <= MILLI_W'(670);
      hi_freq     <= FREQ_W'(1000);
      lo_freq     <= FREQ_W'(300);
      f_gain      <= MILLI_W'(800);
      t_gain      <= MILLI_W'(200);
      t_db        <= MILLI_W'(100);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAL_SAMPLES: cal_samples <= cfg_data[CNT_W-1:0];
        CFG_RANGE:       fs_range    <= cfg_data[RANGE_W-1:0];
        CFG_THRESHOLD:   det_thr     <= cfg_data[MILLI_W-1:0];
        CFG_HIGH_FREQ:   hi_freq     <= cfg_data[FREQ_W-1:0];
        CFG_LOW_FREQ:    lo_freq     <= cfg_data[FREQ_W-1:0];
        CFG_FORCE_GAIN:  f_gain      <= cfg_data[MILLI_W-1:0];
        CFG_TORQUE_GAIN: t_gain      <= cfg_data[MILLI_W-1:0];
        CFG_DEADBAND:    t_db        <= cfg_data[MILLI_W-1:0];
        default:         t_db        <= t_db;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      calibrating <= 1'b1;
      cal_count   <= '0;
      win_fill    <= '0;
      win_slot    <= '0;
      out_valid   <= 1'b0;
      axis        <= '0;
      for (int i = 0; i < AXES; i++) begin
        cal_sums[i] <= '0;
        ref_val[i]  <= '0;
        win_sums[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: axis <= '0;
        ST_CAL_ACC: begin
          cal_count <= cal_count_next;
          for (int i = 0; i < AXES; i++) begin
            cal_sums[i] <= cal_sums[i] + CSUM_W'(samp[i]);
          end
        end
        ST_REF_WAIT: begin
          if (div_rsp.done) begin
            ref_val[axis] <= SAMPLE_W'(sq_quot);
            axis          <= last_axis ? '0 : axis + 1'b1;
            if (last_axis) calibrating <= 1'b0;
          end
        end
        ST_WIN_WR: begin
          win_sums[axis] <= win_sums[axis] + WSUM_W'(samp[axis])
                          - (win_full ? WSUM_W'($signed(ram_rdata)) : '0);
          axis <= last_axis ? '0 : axis + 1'b1;
          if (last_axis) begin
            if (!win_full) win_fill <= win_fill + 1'b1;
            win_slot <= (win_slot == SLOT_W'(WIN_DEPTH - 1)) ? '0 : win_slot + 1'b1;
          end
        end
        ST_AVG_WAIT: begin
          if (div_rsp.done) axis <= last_axis ? '0 : axis + 1'b1;
        end
        ST_SQ_ACC: if (!grp_end) axis <= axis + 1'b1;
        ST_INT_WAIT: if (div_rsp.done && axis == FORCE_LAST) axis <= axis + 1'b1;
        default: axis <= axis;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp[0] <= sample.force_x;
      samp[1] <= sample.force_y;
      samp[2] <= sample.force_z;
      samp[3] <= sample.torque_x;
      samp[4] <= sample.torque_y;
      samp[5] <= sample.torque_z;
    end
    if (state == ST_REF_START || state == ST_AVG_START) begin
      div_neg <= div_sn[DIV_NUM_W];
    end
    if (state == ST_AVG_WAIT && div_rsp.done) begin
      avg[axis] <= SAMPLE_W'(sq_quot);
    end
    if (state == ST_SQ_MUL) begin
      sq <= SQ_W'(diff_mag) * SQ_W'(diff_mag);
    end
    if (state == ST_SQ_ACC) begin
      acc <= (axis == '0 || axis == FORCE_LAST + 1'b1) ? sq : acc + sq;
    end
    if (state == ST_SQRT_INIT) begin
      rt_v   <= acc;
      rt_r   <= '0;
      rt_bit <= SQ_W'(1) << (SQ_W - 2);
    end
    if (state == ST_SQRT) begin
      if (rt_v >= rt_trial) begin
        rt_v <= rt_v - rt_trial;
        rt_r <= (rt_r >> 1) + rt_bit;
      end else begin
        rt_r <= rt_r >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end
    if (state == ST_INT_WAIT && div_rsp.done) begin
      if (axis == FORCE_LAST) begin
        fi <= int_sat;
      end else begin
        ti <= (int_sat < INT_W'(t_db) * THOUSAND) ? '0 : int_sat;
      end
    end
    if (state == ST_COMB_MUL) begin
      p_f <= PROD_W'(f_gain) * PROD_W'(fi);
      p_t <= PROD_W'(t_gain) * PROD_W'(ti);
    end
    if (state == ST_COMB_ADD) begin
      comb <= (comb_sum > (PROD_W+1)'(COMB_MAX)) ? COMB_MAX : comb_sum[INT_W-1:0];
    end
    if (state == ST_MILLI_START) begin
      milli_prod <= MPROD_W'(milli_num[INT_W-1:MILLI_PRE]) * MPROD_W'(MILLI_RECIP);
    end
    if (out_load) begin
      out_int  <= milli_prod[MILLI_SHIFT +: MILLI_W];
      out_freq <= (comb > INT_W'(det_thr) * MICRO) ? hi_freq : lo_freq;
    end
  end

  assign sample.ready           = state == ST_IDLE;
  assign result.valid           = out_valid;
  assign result.intensity_milli = out_int;
  assign result.frequency_milli = out_freq;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    win_fill <= FILL_W'(WIN_DEPTH))
    else $error("window fill past depth");

  a_cal_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CAL_ACC || state == ST_REF_START) |-> calibrating)
    else $error("calibration step after calibration ended");

  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !calibrating && $past(state) == ST_WIN_RD)
    else $error("window write without preceding read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ----- rtl/fticu_ram.sv -----
module fticu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fticu_div.sv -----
module fticu_div (
  input  logic                clk,
  input  logic                rst,
  input  fticu_pkg::div_req_t req,
  output fticu_pkg::div_rsp_t rsp
);
  import fticu_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quo[DIV_NUM_W-1]};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.quot   = quo;
  assign rsp.rem_nz = |rem;

endmodule

// ----- tb/sv/force_torque_collision_intensity_unit_tb.sv -----
module force_torque_collision_intensity_unit_tb;
  import fticu_pkg::*;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] ft_sample_t;

  typedef struct {
    logic [MILLI_W-1:0] milli;
    logic [FREQ_W-1:0]  freq;
  } intensity_t;

  localparam int IDLE_LIMIT = 40000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fticu_sample_if smp();
  fticu_result_if res();

  force_torque_collision_intensity_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(smp),
    .result(res)
  );

  // predictor copy of the settings
  logic [15:0] cal_need_reg;
  logic [22:0] range_reg;
  logic [9:0]  thresh_reg;
  logic [15:0] hi_freq_reg;
  logic [15:0] lo_freq_reg;
  logic [9:0]  fgain_reg;
  logic [9:0]  tgain_reg;
  logic [9:0]  deadband_reg;

  // predictor copy of the state
  bit      calibrating;
  int      cal_count;
  longint  cal_sum [AXES];
  longint  baseline [AXES];
  longint  win_mem [RAM_DEPTH];
  longint  win_sum [AXES];
  int      win_fill;
  int      win_slot;

  intensity_t pending_results[$];
  int  error_count;
  int  idle_cycles;
  bit  calm;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint round_div(longint num, longint den);
    longint n;
    longint d;
    longint q;
    n = 2 * num + den;
    d = 2 * den;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned norm_micro(longint avg [AXES], int first,
                                                 longint unsigned rng);
    longint unsigned acc;
    longint d;
    acc = 0;
    for (int i = first; i < first + 3; i++) begin
      d = avg[i] - baseline[i];
      if (d < 0) d = -d;
      acc += longint'(d) * longint'(d);
    end
    return root_floor(acc) * 64'd1000000 / rng;
  endfunction

  task automatic predict_intensity(ft_sample_t s);
    longint v [AXES];
    longint avg [AXES];
    longint unsigned rng, fi, ti, comb;
    int need;
    intensity_t r;
    for (int i = 0; i < AXES; i++) v[i] = longint'(signed'(s[i]));
    if (calibrating) begin
      for (int i = 0; i < AXES; i++) cal_sum[i] += v[i];
      if (cal_count < 65535) cal_count++;
      need = (cal_need_reg == 0) ? 1 : int'(cal_need_reg);
      if (cal_count >= need) begin
        for (int i = 0; i < AXES; i++) baseline[i] = round_div(cal_sum[i], cal_count);
        calibrating = 0;
      end
      return;
    end
    for (int i = 0; i < AXES; i++) begin
      if (win_fill >= WIN_DEPTH) win_sum[i] -= win_mem[win_slot * AXES + i];
      win_mem[win_slot * AXES + i] = v[i];
      win_sum[i] += v[i];
    end
    if (win_fill < WIN_DEPTH) win_fill++;
    win_slot = (win_slot + 1) % WIN_DEPTH;
    for (int i = 0; i < AXES; i++) avg[i] = round_div(win_sum[i], win_fill);
    rng = (range_reg == 0) ? 1 : range_reg;
    fi = norm_micro(avg, 0, rng);
    ti = norm_micro(avg, 3, rng);
    if (ti < longint'(deadband_reg) * 1000) ti = 0;
    comb = longint'(fgain_reg) * fi + longint'(tgain_reg) * ti;
    if (comb > 64'd1000000000) comb = 64'd1000000000;
    r.milli = MILLI_W'((comb + 64'd500000) / 64'd1000000);
    r.freq = (comb > longint'(thresh_reg) * 1000000) ? hi_freq_reg : lo_freq_reg;
    pending_results.insert(pending_results.size(), r);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm) return 0;
    if (p < 80) return $urandom_range(0, 3);
    if (p < 95) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  task automatic send_sample(ft_sample_t s);
    repeat (gap_len()) @(posedge clk);
    @(posedge clk);
    smp.valid <= 1'b1;
    smp.force_x <= s[0];
    smp.force_y <= s[1];
    smp.force_z <= s[2];
    smp.torque_x <= s[3];
    smp.torque_y <= s[4];
    smp.torque_z <= s[5];
    do @(posedge clk); while (!smp.ready);
    predict_intensity(s);
    smp.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_results.size() != 0 || !smp.ready);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CAL_SAMPLES: cal_need_reg = val[15:0];
      CFG_RANGE:       range_reg = val[22:0];
      CFG_THRESHOLD:   thresh_reg = val[9:0];
      CFG_HIGH_FREQ:   hi_freq_reg = val[15:0];
      CFG_LOW_FREQ:    lo_freq_reg = val[15:0];
      CFG_FORCE_GAIN:  fgain_reg = val[9:0];
      CFG_TORQUE_GAIN: tgain_reg = val[9:0];
      default:         deadband_reg = val[9:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int rng, int thr, int hi, int lo, int fg, int tg, int db);
    wait_idle();
    write_reg(CFG_RANGE, CFG_W'(rng));
    write_reg(CFG_THRESHOLD, CFG_W'(thr));
    write_reg(CFG_HIGH_FREQ, CFG_W'(hi));
    write_reg(CFG_LOW_FREQ, CFG_W'(lo));
    write_reg(CFG_FORCE_GAIN, CFG_W'(fg));
    write_reg(CFG_TORQUE_GAIN, CFG_W'(tg));
    write_reg(CFG_DEADBAND, CFG_W'(db));
  endtask

  function automatic ft_sample_t uniform_sample();
    ft_sample_t s;
    for (int i = 0; i < AXES; i++) s[i] = SAMPLE_W'($urandom);
    return s;
  endfunction

  function automatic ft_sample_t fill_sample(logic [SAMPLE_W-1:0] v);
    ft_sample_t s;
    for (int i = 0; i < AXES; i++) s[i] = v;
    return s;
  endfunction

  // baseline plus a deviation of random magnitude, separate for force and torque
  function automatic ft_sample_t near_baseline(int fbits, int tbits);
    ft_sample_t s;
    longint v;
    int b;
    for (int i = 0; i < AXES; i++) begin
      b = (i < 3) ? fbits : tbits;
      v = longint'($urandom_range(0, (1 << b) - 1));
      if ($urandom_range(0, 1)) v = -v;
      v += baseline[i];
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      s[i] = SAMPLE_W'(v);
    end
    return s;
  endfunction

  task automatic test_calibration();
    write_reg(CFG_CAL_SAMPLES, CFG_W'(0));
    write_reg(CFG_CAL_SAMPLES, CFG_W'(20));
    send_sample(fill_sample(24'h7FFFFF));
    send_sample(fill_sample(24'h800000));
    for (int i = 0; i < 3; i++) send_sample(near_baseline(12, 12));
    // lowering the count below what was taken ends calibration on the next sample
    wait_idle();
    write_reg(CFG_CAL_SAMPLES, CFG_W'(3));
    send_sample(near_baseline(10, 10));
    wait_idle();
    write_reg(CFG_CAL_SAMPLES, CFG_W'(65535));
  endtask

  task automatic test_directed();
    apply_settings(6144, 670, 1000, 300, 800, 200, 100);
    send_sample(fill_sample(24'h7FFFFF));
    send_sample(fill_sample(24'h800000));
    send_sample(fill_sample(24'h000000));
    for (int i = 0; i < 4; i++) send_sample(near_baseline(0, 0));
    for (int i = 0; i < 3; i++) send_sample(near_baseline(13, 9));
    // zero range reads as one: saturates
    apply_settings(0, 0, 65535, 0, 1000, 1000, 0);
    send_sample(near_baseline(4, 4));
    send_sample(near_baseline(0, 0));
    apply_settings(8388607, 1000, 0, 65535, 0, 1000, 1000);
    send_sample(fill_sample(24'h7FFFFF));
    send_sample(fill_sample(24'h800000));
    apply_settings(4096, 500, 1234, 4321, 1000, 0, 1000);
    for (int i = 0; i < 5; i++) send_sample(near_baseline(12, 16));
  endtask

  task automatic test_random();
    int rng;
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 5))
        0: rng = 1;
        1: rng = 8388607;
        default: rng = $urandom_range(1, 1 << $urandom_range(4, 22));
      endcase
      apply_settings(rng, $urandom_range(0, 1000), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 1000),
                     $urandom_range(0, 1000), $urandom_range(0, 1000));
      calm = (ph % 5 == 3);
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(uniform_sample());
        else
          send_sample(near_baseline($urandom_range(0, 22), $urandom_range(0, 22)));
      end
      calm = 0;
    end
  endtask

  always @(posedge clk) begin
    if (calm) begin
      res.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    intensity_t exp_r;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transaction: intensity %0d frequency %0d", $time,
                 res.intensity_milli, res.frequency_milli);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res.intensity_milli !== exp_r.milli) begin
          $display("%0t intensity_milli expected %0d actual %0d", $time, exp_r.milli,
                   res.intensity_milli);
          error_count++;
        end
        if (res.frequency_milli !== exp_r.freq) begin
          $display("%0t frequency_milli expected %0d actual %0d", $time, exp_r.freq,
                   res.frequency_milli);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.force_x = '0;
    smp.force_y = '0;
    smp.force_z = '0;
    smp.torque_x = '0;
    smp.torque_y = '0;
    smp.torque_z = '0;
    res.ready = 1'b0;
    calm = 0;
    stall_left = 0;
    idle_cycles = 0;
    error_count = 0;
    cal_need_reg = 500;
    range_reg = 6144;
    thresh_reg = 670;
    hi_freq_reg = 1000;
    lo_freq_reg = 300;
    fgain_reg = 800;
    tgain_reg = 200;
    deadband_reg = 100;
    calibrating = 1;
    cal_count = 0;
    for (int i = 0; i < AXES; i++) begin
      cal_sum[i] = 0;
      baseline[i] = 0;
      win_sum[i] = 0;
    end
    win_fill = 0;
    win_slot = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_calibration();
    test_directed();
    test_random();
    wait_idle();
    repeat (600) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
